@@ src/lpfr_pkg.sv @@
// package for the length-prefixed frame receiver
// token format between front and back, codes, constants and the crc-16 byte update
// no dependencies
`default_nettype none

package lpfr_pkg;

    localparam int          LEN_W         = 24;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  END_BYTE      = 8'd3;
    localparam logic [7:0]  START_MIN     = 8'd2;
    localparam logic [7:0]  START_MAX     = 8'd4;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd512;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [2:0] TK_DATA   = 3'd0;
    localparam logic [2:0] TK_CRC_HI = 3'd1;
    localparam logic [2:0] TK_CRC_LO = 3'd2;
    localparam logic [2:0] TK_END    = 3'd3;
    localparam logic [2:0] TK_LONG   = 3'd4;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_CRC_ERR  = 2'd1;
    localparam logic [1:0] ST_BAD_END  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [2:0]       code;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } t_token;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/lpfr_if.sv @@
// channel interfaces of the frame receiver: byte input, result output, config write
// no dependencies
`default_nettype none

interface lpfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  out_data;
    logic [1:0]  frame_status;
    logic [23:0] frame_length;

    modport source (output valid, output out_kind, output out_data, output frame_status,
                    output frame_length, input ready);
    modport sink   (input valid, input out_kind, input out_data, input frame_status,
                    input frame_length, output ready);
endinterface

interface lpfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] max_payload_len;

    modport source (output valid, output max_payload_len, input ready);
    modport sink   (input valid, input max_payload_len, output ready);
endinterface

`default_nettype wire

@@ src/lpfr_front.sv @@
// front part: frame parser that hunts, decodes length, counts payload, emits tokens
// depends on lpfr_pkg and lpfr_if
`default_nettype none

module lpfr_front import lpfr_pkg::*; #(
    parameter int LENGTH_WIDTH = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lpfr_in_if.sink     i_in,
    lpfr_cfg_if.sink    i_cfg,
    input  wire         i_q_full,
    output logic        o_push,
    output t_token      o_token
);

    localparam int unsigned LIMIT_INT = (1 << LENGTH_WIDTH) - 1;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LIMIT_INT);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_CRC_HI = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;
    localparam logic [2:0] PH_END    = 3'd5;

    logic [2:0]              r_phase, n_phase;
    logic [1:0]              r_len_left, n_len_left;
    logic [LEN_W-1:0]        r_len, n_len;
    logic [LENGTH_WIDTH-1:0] r_count, n_count;
    logic [LEN_W-1:0]        r_max;

    logic                    w_accept;
    logic                    w_emit;
    logic [7:0]              w_b;
    logic [7:0]              w_left_m1;
    logic [LEN_W-1:0]        w_len_shift;
    logic [LENGTH_WIDTH-1:0] w_count_inc;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_b         = i_in.rx_byte;
    assign w_left_m1   = w_b - 8'd1;
    assign w_len_shift = {r_len[LEN_W-9:0], w_b};
    assign w_count_inc = r_count + 1'b1;
    assign o_push      = w_accept && w_emit;

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_len      = r_len;
        n_count    = r_count;
        w_emit     = 1'b0;
        o_token    = '{code: TK_DATA, data: w_b, len: r_len};
        case (r_phase)
            PH_HUNT: begin
                if (w_b >= START_MIN && w_b <= START_MAX) begin
                    n_phase    = PH_LEN;
                    n_len_left = w_left_m1[1:0];
                    n_len      = '0;
                    n_count    = '0;
                end
            end
            PH_LEN: begin
                n_len      = w_len_shift;
                n_len_left = r_len_left - 2'd1;
                if (n_len_left == 2'd0) begin
                    n_count = '0;
                    if (w_len_shift > r_max || w_len_shift > LEN_LIMIT) begin
                        w_emit  = 1'b1;
                        o_token = '{code: TK_LONG, data: 8'd0, len: w_len_shift};
                        n_phase = PH_HUNT;
                        n_len   = '0;
                    end else if (w_len_shift == '0) begin
                        n_phase = PH_CRC_HI;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                w_emit  = 1'b1;
                n_count = w_count_inc;
                if (w_count_inc == r_len[LENGTH_WIDTH-1:0]) begin
                    n_phase = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                w_emit       = 1'b1;
                o_token.code = TK_CRC_HI;
                n_phase      = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                w_emit       = 1'b1;
                o_token.code = TK_CRC_LO;
                n_phase      = PH_END;
            end
            PH_END: begin
                w_emit       = 1'b1;
                o_token.code = TK_END;
                n_phase      = PH_HUNT;
                n_len        = '0;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_len_left <= '0;
            r_len      <= '0;
            r_count    <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_len      <= n_len;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max <= i_cfg.max_payload_len;
        end
    end

    a_len_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN) |-> (r_len_left != 2'd0))
        else $error("length phase with no length bytes left");

    a_data_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != '0 && r_len <= LEN_LIMIT))
        else $error("payload phase with empty or oversized length");

endmodule

`default_nettype wire

@@ src/lpfr_queue.sv @@
// token queue between parser and crc/status back end
// depends on lpfr_pkg
`default_nettype none

module lpfr_queue import lpfr_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_token i_token,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_token,
    input  wire    i_pop
);

    t_token             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("token pushed into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ src/lpfr_back.sv @@
// back part: running crc, received crc capture, result register toward the output
// depends on lpfr_pkg and lpfr_if
`default_nettype none

module lpfr_back import lpfr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_valid,
    input  t_token      i_token,
    output logic        o_pop,
    lpfr_out_if.source  o_out
);

    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_rx_crc, n_rx_crc;
    logic             r_out_valid, n_out_valid;
    logic             r_kind, n_kind;
    logic [7:0]       r_data, n_data;
    logic [1:0]       r_status, n_status;
    logic [LEN_W-1:0] r_len, n_len;

    logic w_slot_free;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign o_pop       = i_q_valid && w_slot_free;

    assign o_out.valid        = r_out_valid;
    assign o_out.out_kind     = r_kind;
    assign o_out.out_data     = r_data;
    assign o_out.frame_status = r_status;
    assign o_out.frame_length = r_len;

    always_comb begin
        n_crc       = r_crc;
        n_rx_crc    = r_rx_crc;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_status    = r_status;
        n_len       = r_len;
        if (o_pop) begin
            case (i_token.code)
                TK_DATA: begin
                    n_crc       = crc_byte(r_crc, i_token.data);
                    n_out_valid = 1'b1;
                    n_kind      = 1'b0;
                    n_data      = i_token.data;
                    n_status    = ST_GOOD;
                    n_len       = '0;
                end
                TK_CRC_HI: begin
                    n_rx_crc = {i_token.data, r_rx_crc[7:0]};
                end
                TK_CRC_LO: begin
                    n_rx_crc = {r_rx_crc[15:8], i_token.data};
                end
                TK_END: begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_data      = 8'd0;
                    n_len       = i_token.len;
                    if (i_token.data != END_BYTE) begin
                        n_status = ST_BAD_END;
                    end else if (r_rx_crc != r_crc) begin
                        n_status = ST_CRC_ERR;
                    end else begin
                        n_status = ST_GOOD;
                    end
                    n_crc    = '0;
                    n_rx_crc = '0;
                end
                TK_LONG: begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_data      = 8'd0;
                    n_status    = ST_TOO_LONG;
                    n_len       = i_token.len;
                    n_crc       = '0;
                    n_rx_crc    = '0;
                end
                default: begin
                    n_crc = r_crc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_rx_crc    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_rx_crc    <= n_rx_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_status <= n_status;
        r_len    <= n_len;
    end

    a_payload_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_kind) |-> (r_status == ST_GOOD && r_len == '0))
        else $error("payload transfer with nonzero status or length");

endmodule

`default_nettype wire

@@ src/length_prefixed_frame_receiver_core.sv @@
// top level of the length-prefixed frame receiver with crc-16/xmodem check
// depends on lpfr_pkg, lpfr_if, lpfr_front, lpfr_queue, lpfr_back
`default_nettype none

// Takes one serial byte per clock cycle while the queue is not full. The front end parses
// a byte in the cycle it is accepted and queues any token it yields in a four-entry queue;
// the back end pops one token a cycle while its output register is free, updates the crc
// and loads the output register. Output stalls are absorbed by the queue; input ready
// drops only when the queue is full. No clearing pass after reset.
module length_prefixed_frame_receiver_core import lpfr_pkg::*; #(
    parameter int LENGTH_WIDTH = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lpfr_in_if.sink     i_in,
    lpfr_cfg_if.sink    i_cfg,
    lpfr_out_if.source  o_out
);

    logic   w_push;
    t_token w_push_token;
    logic   w_q_full;
    logic   w_q_valid;
    t_token w_q_token;
    logic   w_pop;

    lpfr_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_token  (w_push_token)
    );

    lpfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_token (w_q_token),
        .i_pop   (w_pop)
    );

    lpfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_token   (w_q_token),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
